FILE: rtl/weighted_index_sampler_macros.svh
// Assertion macros for the weighted index sampler.
// Used by the top level; expects clk and rst_n in scope.
`ifndef WEIGHTED_INDEX_SAMPLER_MACROS_SVH
`define WEIGHTED_INDEX_SAMPLER_MACROS_SVH

// same-cycle implication
`define WIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wis_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// weighted index sampler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wis_pkg;

  localparam int NUM_ENTRIES_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int RANDOM_BITS_DEF = 16;

  localparam int IDX_PORT_W    = 6;
  localparam int WEIGHT_PORT_W = 16;
  localparam int RAND_PORT_W   = 16;
  localparam int CFG_W         = 7;
  localparam int EXT_W         = 48;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  typedef struct packed {
    logic clr_en;
    logic wr_en;
    logic draw_load;
    logic sum_en;
    logic mul_start;
    logic mul_en;
    logic scan_start;
    logic scan_en;
    logic out_load;
  } wis_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic sum_done;
    logic mul_done;
    logic scan_done;
  } wis_stat_t;

endpackage

`default_nettype wire

FILE: rtl/wis_datapath.sv
// Datapath: weight memory, entry count register, sum walk, shift-add scaler,
// scan walk and result register. Depends on wis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wis_datapath import wis_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wis_cmd_t                 cmd,
  output wis_stat_t                stat,
  input  wire [IDX_PORT_W-1:0]     in_entry_index,
  input  wire [WEIGHT_PORT_W-1:0]  in_weight_value,
  input  wire [RAND_PORT_W-1:0]    in_random_fraction,
  input  wire                      cfg_we,
  input  wire [CFG_W-1:0]          cfg_wdata,
  output logic [IDX_PORT_W-1:0]    out_selected_index
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int SUM_W = WEIGHT_BITS + IDX_W;
  localparam int MC_W  = $clog2(RANDOM_BITS);

  logic [WEIGHT_BITS-1:0] mem [0:NUM_ENTRIES-1];
  logic [WEIGHT_BITS-1:0] rdata_r;

  logic [CFG_W-1:0]       cfg_r, cfg_nxt;
  logic [EXT_W-1:0]       cfg_ext, cfg_m1;
  logic [IDX_W-1:0]       last_idx;

  logic [EXT_W-1:0]       widx_ext, wv_ext, rf_ext, res_ext;
  logic                   wr_in_range;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;

  logic [IDX_W-1:0]       addr_r, addr_nxt;
  logic                   issuing_r, issuing_nxt;
  logic                   rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   walk_start, walk_en;

  logic [SUM_W-1:0]       sum_r, h_r, run_r, target_r, run_nxt;
  logic [RANDOM_BITS-1:0] l_r;
  logic [SUM_W:0]         mul_t;
  logic [MC_W-1:0]        mcnt_r, mcnt_nxt;
  logic                   hit;
  logic [IDX_W-1:0]       res_r;
  logic [IDX_PORT_W-1:0]  out_idx_r;

  always_comb begin
    cfg_ext = EXT_W'(cfg_r);
    cfg_m1  = cfg_ext - EXT_W'(1);
    priority if (cfg_r == '0) begin
      last_idx = '0;
    end else if (cfg_ext > EXT_W'(NUM_ENTRIES)) begin
      last_idx = IDX_W'(NUM_ENTRIES - 1);
    end else begin
      last_idx = cfg_m1[IDX_W-1:0];
    end
  end

  assign widx_ext    = EXT_W'(in_entry_index);
  assign wv_ext      = EXT_W'(in_weight_value);
  assign rf_ext      = EXT_W'(in_random_fraction);
  assign wr_in_range = widx_ext < EXT_W'(NUM_ENTRIES);

  assign mem_we    = cmd.clr_en | (cmd.wr_en & wr_in_range);
  assign mem_waddr = cmd.clr_en ? addr_r : widx_ext[IDX_W-1:0];
  assign mem_wdata = cmd.clr_en ? '0 : wv_ext[WEIGHT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  assign walk_start = cmd.draw_load | cmd.scan_start;
  assign walk_en    = cmd.sum_en | cmd.scan_en;

  always_comb begin
    cfg_nxt     = cfg_we ? cfg_wdata : cfg_r;
    addr_nxt    = addr_r;
    issuing_nxt = issuing_r;
    rd_v_nxt    = rd_v_r;
    priority if (cmd.clr_en) begin
      addr_nxt = addr_r + IDX_W'(1);
    end else if (walk_start) begin
      addr_nxt    = '0;
      issuing_nxt = 1'b1;
      rd_v_nxt    = 1'b0;
    end else if (walk_en) begin
      rd_v_nxt = issuing_r;
      if (issuing_r) begin
        if (addr_r == last_idx) begin
          issuing_nxt = 1'b0;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end
    end
    priority if (cmd.mul_start) begin
      mcnt_nxt = '0;
    end else if (cmd.mul_en) begin
      mcnt_nxt = mcnt_r + MC_W'(1);
    end else begin
      mcnt_nxt = mcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= CFG_RESET;
      addr_r    <= '0;
      issuing_r <= 1'b0;
      rd_v_r    <= 1'b0;
      mcnt_r    <= '0;
    end else begin
      cfg_r     <= cfg_nxt;
      addr_r    <= addr_nxt;
      issuing_r <= issuing_nxt;
      rd_v_r    <= rd_v_nxt;
      mcnt_r    <= mcnt_nxt;
    end
  end

  assign mul_t   = {1'b0, h_r} + (l_r[0] ? {1'b0, sum_r} : '0);
  assign run_nxt = run_r + SUM_W'(rdata_r);
  assign hit     = run_nxt >= target_r;
  assign res_ext = EXT_W'(res_r);

  always_ff @(posedge clk) begin
    if (walk_en) begin
      rd_idx_r <= addr_r;
    end
    if (cmd.draw_load) begin
      sum_r <= '0;
      l_r   <= rf_ext[RANDOM_BITS-1:0];
    end else begin
      if (cmd.sum_en && rd_v_r) begin
        sum_r <= sum_r + SUM_W'(rdata_r);
      end
      if (cmd.mul_en) begin
        l_r <= {mul_t[0], l_r[RANDOM_BITS-1:1]};
      end
    end
    if (cmd.mul_start) begin
      h_r <= '0;
    end else if (cmd.mul_en) begin
      h_r <= mul_t[SUM_W:1];
    end
    target_r <= h_r + SUM_W'(|l_r);
    if (cmd.scan_start) begin
      run_r <= '0;
    end else if (cmd.scan_en && rd_v_r) begin
      run_r <= run_nxt;
      res_r <= rd_idx_r;
    end
    if (cmd.out_load) begin
      out_idx_r <= res_ext[IDX_PORT_W-1:0];
    end
  end

  assign stat.clear_last = addr_r == IDX_W'(NUM_ENTRIES - 1);
  assign stat.sum_done   = rd_v_r && (rd_idx_r == last_idx);
  assign stat.mul_done   = mcnt_r == MC_W'(RANDOM_BITS - 1);
  assign stat.scan_done  = rd_v_r && (hit || (rd_idx_r == last_idx));

  assign out_selected_index = out_idx_r;

endmodule

`default_nettype wire

FILE: rtl/wis_ctrl.sv
// Controller: sequences memory clear, weight writes and the sum, scale and
// scan phases of a draw; owns the handshakes. Depends on wis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wis_ctrl import wis_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  wire        out_ready,
  input  wis_stat_t  stat,
  output wis_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SUM   = 6'b000100,
    S_MUL   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, slot_free;

  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid & in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.wr_en     = accept && (in_kind == KIND_WRITE);
        cmd.draw_load = accept && (in_kind == KIND_DRAW);
        if (cmd.draw_load) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        if (stat.sum_done) begin
          cmd.mul_start = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (stat.mul_done) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.out_load = slot_free;
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/weighted_index_sampler.sv
// Channel   Direction  Handshake         Payload
// in_       input      valid / ready     kind, entry_index, weight_value, random_fraction
// out_      output     valid / ready     selected_index
// cfg_      input      write enable      entries_in_use (n)
//
// After reset the weight memory is zeroed, one entry a cycle, with in_ready low. A draw
// runs from transfer to out_valid through a sum walk, the scaler and a scan walk that stops
// at the chosen index: two walks over the single memory read port plus a one-bit-per-cycle
// shift-add scaler.
// A finished draw waits in the output register; writes are taken meanwhile, the next
// draw result holds until the output register frees.
// Top level: wis_ctrl plus wis_datapath; depends on wis_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_index_sampler_macros.svh"

module weighted_index_sampler import wis_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      in_kind,
  input  wire [IDX_PORT_W-1:0]     in_entry_index,
  input  wire [WEIGHT_PORT_W-1:0]  in_weight_value,
  input  wire [RAND_PORT_W-1:0]    in_random_fraction,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [IDX_PORT_W-1:0]    out_selected_index,
  input  wire                      cfg_we,
  input  wire [CFG_W-1:0]          cfg_wdata
);

  wis_cmd_t  cmd;
  wis_stat_t stat;

  wis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wis_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_entry_index     (in_entry_index),
    .in_weight_value    (in_weight_value),
    .in_random_fraction (in_random_fraction),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_selected_index (out_selected_index)
  );

  `WIS_ASSERT_NEXT(a_draw_blocks_intake, in_valid && in_ready && (in_kind == KIND_DRAW), !in_ready, "intake open right after a draw transfer")
  `WIS_ASSERT_NOW(a_clear_blocks_intake, cmd.clr_en, !in_ready, "intake open during memory clear")
  `WIS_ASSERT_NOW(a_index_in_table, out_valid, EXT_W'(out_selected_index) < EXT_W'(NUM_ENTRIES), "selected index beyond table")

endmodule

`default_nettype wire
